// File: rtl/tbes_pkg.sv
// tbes_pkg: shared constants, types and state encoding for the time-binned energy sum unit.
// No dependencies; used by tbes_ctrl, tbes_dp and time_binned_energy_sum_unit.

package tbes_pkg;

    localparam int WORDS_PER_BOARD = 8;          // words per board, 1 to 16
    localparam int NUM_BINS        = 8;
    localparam int ENERGY_W        = 13;
    localparam int BIN_W           = 3;
    localparam int SUM_W           = 14;
    localparam int CFG_W           = 16;         // one enable bit per channel
    localparam int NUM_CH          = 2 * WORDS_PER_BOARD;
    localparam int EN_W            = (NUM_CH > CFG_W) ? NUM_CH : CFG_W;
    localparam int WIDX_W          = (WORDS_PER_BOARD > 1) ? $clog2(WORDS_PER_BOARD) : 1;
    // worst case: every hit of the board at full scale in one bin
    localparam int ACC_W           = $clog2(NUM_CH * ((1 << ENERGY_W) - 1) + 1);
    localparam int IN_DATA_W       = 32;
    localparam int OUT_DATA_W      = 16;

    localparam logic [SUM_W-1:0]  SUM_MAX  = 14'h3FFF;
    localparam logic [BIN_W-1:0]  BIN_LAST = BIN_W'(NUM_BINS - 1);
    localparam logic [WIDX_W-1:0] WIDX_LAST = WIDX_W'(WORDS_PER_BOARD - 1);
    localparam logic [CFG_W-1:0]  ENABLE_RESET = 16'hFFFF;

    typedef enum logic
    {
        ST_ACCUM,
        ST_EMIT
    } tbes_state_t;

    // controller -> datapath
    typedef struct packed
    {
        logic accum;   // add the accepted word into the bins
        logic load;    // move the current bin sum into the output register
    } tbes_cmd_t;

    // datapath -> controller
    typedef struct packed
    {
        logic last_word;  // word counter at the final word of the board
        logic last_bin;   // emit counter at bin 7
        logic out_free;   // output register empty or being drained
    } tbes_stat_t;

endpackage

// File: rtl/tbes_ctrl.sv
// tbes_ctrl: two-state sequencer, accumulate a board then emit its eight bin sums.
// Depends on tbes_pkg.

module tbes_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  tbes_pkg::tbes_stat_t stat,
    output tbes_pkg::tbes_cmd_t  cmd
);

    tbes_pkg::tbes_state_t state_reg;
    tbes_pkg::tbes_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tbes_pkg::ST_ACCUM;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tbes_pkg::ST_ACCUM:
            begin
                if (s_tvalid && stat.last_word)
                begin
                    state_next = tbes_pkg::ST_EMIT;
                end
            end
            tbes_pkg::ST_EMIT:
            begin
                if (stat.out_free && stat.last_bin)
                begin
                    state_next = tbes_pkg::ST_ACCUM;
                end
            end
            default:
            begin
                state_next = tbes_pkg::ST_ACCUM;
            end
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        cmd.accum = 1'b0;
        cmd.load  = 1'b0;
        case (state_reg)
            tbes_pkg::ST_ACCUM:
            begin
                s_tready  = 1'b1;
                cmd.accum = s_tvalid;
            end
            tbes_pkg::ST_EMIT:
            begin
                cmd.load = stat.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/tbes_dp.sv
// tbes_dp: enable register, word/bin counters, eight bin accumulators, output register.
// Depends on tbes_pkg; driven by tbes_ctrl commands.

module tbes_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [tbes_pkg::CFG_W-1:0]          cfg_data,
    input  logic [tbes_pkg::IN_DATA_W-1:0]      s_tdata,
    input  tbes_pkg::tbes_cmd_t                 cmd,
    output tbes_pkg::tbes_stat_t                stat,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tbes_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [tbes_pkg::BIN_W-1:0]          m_tuser,
    output logic                                m_tlast
);

    logic [tbes_pkg::CFG_W-1:0]    enable_reg;
    logic [tbes_pkg::WIDX_W-1:0]   word_idx_reg;
    logic [tbes_pkg::WIDX_W-1:0]   word_idx_next;
    logic [tbes_pkg::BIN_W-1:0]    emit_idx_reg;
    logic [tbes_pkg::ACC_W-1:0]    acc_reg [tbes_pkg::NUM_BINS];
    logic [tbes_pkg::ACC_W-1:0]    acc_next [tbes_pkg::NUM_BINS];
    logic                          out_valid_reg;
    logic [tbes_pkg::SUM_W-1:0]    out_sum_reg;
    logic [tbes_pkg::BIN_W-1:0]    out_bin_reg;
    logic                          out_last_reg;

    logic [tbes_pkg::ENERGY_W-1:0] e_even;
    logic [tbes_pkg::BIN_W-1:0]    t_even;
    logic [tbes_pkg::ENERGY_W-1:0] e_odd;
    logic [tbes_pkg::BIN_W-1:0]    t_odd;
    logic [tbes_pkg::EN_W-1:0]     en_ext;
    logic [1:0]                    en_pair;
    logic [tbes_pkg::ACC_W-1:0]    add_even;
    logic [tbes_pkg::ACC_W-1:0]    add_odd;
    logic [tbes_pkg::ACC_W-1:0]    sel_acc;
    logic [tbes_pkg::SUM_W-1:0]    sat_sum;

    assign e_even = s_tdata[12:0];
    assign t_even = s_tdata[15:13];
    assign e_odd  = s_tdata[28:16];
    assign t_odd  = s_tdata[31:29];

    // channels above 15 have no enable bit and read as disabled
    assign en_ext   = tbes_pkg::EN_W'(enable_reg);
    assign en_pair  = en_ext[{word_idx_reg, 1'b0} +: 2];
    assign add_even = en_pair[0] ? tbes_pkg::ACC_W'(e_even) : '0;
    assign add_odd  = en_pair[1] ? tbes_pkg::ACC_W'(e_odd) : '0;

    assign word_idx_next = (word_idx_reg == tbes_pkg::WIDX_LAST) ? '0
                         : word_idx_reg + tbes_pkg::WIDX_W'(1);

    always_comb
    begin
        for (int b = 0; b < tbes_pkg::NUM_BINS; b++)
        begin
            acc_next[b] = acc_reg[b]
                        + ((t_even == tbes_pkg::BIN_W'(b)) ? add_even : '0)
                        + ((t_odd == tbes_pkg::BIN_W'(b)) ? add_odd : '0);
        end
    end

    assign sel_acc = acc_reg[emit_idx_reg];
    assign sat_sum = (sel_acc > tbes_pkg::ACC_W'(tbes_pkg::SUM_MAX)) ? tbes_pkg::SUM_MAX
                   : sel_acc[tbes_pkg::SUM_W-1:0];

    assign stat.last_word = (word_idx_reg == tbes_pkg::WIDX_LAST);
    assign stat.last_bin  = (emit_idx_reg == tbes_pkg::BIN_LAST);
    assign stat.out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= tbes_pkg::ENABLE_RESET;
            word_idx_reg  <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < tbes_pkg::NUM_BINS; b++)
            begin
                acc_reg[b] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                enable_reg <= cfg_data;
            end
            if (cmd.accum)
            begin
                word_idx_reg <= word_idx_next;
                for (int b = 0; b < tbes_pkg::NUM_BINS; b++)
                begin
                    acc_reg[b] <= acc_next[b];
                end
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
                emit_idx_reg  <= emit_idx_reg + tbes_pkg::BIN_W'(1);
                if (stat.last_bin)
                begin
                    for (int b = 0; b < tbes_pkg::NUM_BINS; b++)
                    begin
                        acc_reg[b] <= '0;
                    end
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_sum_reg  <= sat_sum;
            out_bin_reg  <= emit_idx_reg;
            out_last_reg <= stat.last_bin;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = tbes_pkg::OUT_DATA_W'(out_sum_reg);
    assign m_tuser  = out_bin_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/time_binned_energy_sum_unit.sv
// time_binned_energy_sum_unit: top level, sequencer plus datapath.
// Depends on tbes_pkg, tbes_ctrl and tbes_dp.

// Usage
//   Input stream (s_*): one request per board word, two hits each; a board is
//   WORDS_PER_BOARD (8) words. No tlast; the word counter frames the board.
//   Output stream (m_*): after the last word, eight requests, bins 0..7 in order;
//   tuser is the bin, tdata the saturated sum, tlast marks bin 7.
//   Config channel (cfg_*): always ready; writes the 16-bit channel enable
//   mask. Write it only while the block is idle.
// Timing
//   Words are taken one per cycle while s_tready is high (the eight accumulators
//   update in parallel). After the last word the state register moves to the emit
//   phase, which then loads the first sum into the output register; one sum can
//   leave per cycle through the single output register while m_tready is high.
//   s_tready drops during the emit phase and returns as soon as bin 7 has been
//   loaded into the output register, so the next board can start while that
//   sum is still waiting.
// Stall: a low m_tready holds the output register and stops the emit counter.
// Reset: accumulators and counters clear, mask returns to all enabled.

module time_binned_energy_sum_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    // config write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tbes_pkg::CFG_W-1:0]       cfg_data,     // channel_enable[15:0]
    // board words
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // energy_even[12:0], time_even[15:13], energy_odd[28:16], time_odd[31:29]
    input  logic [tbes_pkg::IN_DATA_W-1:0]   s_tdata,
    // bin sums
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tbes_pkg::OUT_DATA_W-1:0]  m_tdata,      // energy_sum[13:0], zero[15:14]
    output logic [tbes_pkg::BIN_W-1:0]       m_tuser,      // time_bin[2:0]
    output logic                             m_tlast       // last_sum
);

    tbes_pkg::tbes_cmd_t  cmd;
    tbes_pkg::tbes_stat_t stat;

    assign cfg_ready = 1'b1;

    tbes_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tbes_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // the emit counter is not at bin 7 (it is parked at bin 0) whenever words are accepted
    a_accum_at_bin0: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !stat.last_bin)
        else $error("emit counter not at bin 0 while accepting words");

    // tlast is carried only by the bin 7 sum
    a_last_is_bin7: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser == tbes_pkg::BIN_LAST))
        else $error("tlast on a sum other than bin 7");

    // the final word of a board ends acceptance until the bin 7 sum is loaded into the output register
    a_board_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && stat.last_word) |=> !s_tready)
        else $error("input still ready after last word of board");

    // accumulate and emit never overlap
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.accum && cmd.load))
        else $error("accumulate and emit in the same cycle");

endmodule
